FILE: rtl/group_box_layout_defines.svh
// Assertion macros shared by the layout block.
`ifndef GROUP_BOX_LAYOUT_DEFINES_SVH
`define GROUP_BOX_LAYOUT_DEFINES_SVH
`ifndef SYNTH
`define GBL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GBL_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBL_ASSERT(label, clk, rst, prop, msg)
`define GBL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: rtl/gbl_pkg.sv
package gbl_pkg;
   localparam int CW = 24;
   localparam int WW = 32;

   localparam logic [2:0] CSR_MODE   = 3'd0;
   localparam logic [2:0] CSR_MARGIN = 3'd1;
   localparam logic [2:0] CSR_MAXDIF = 3'd2;
   localparam logic [2:0] CSR_ORGX   = 3'd3;
   localparam logic [2:0] CSR_ORGY   = 3'd4;

   typedef struct packed {
      logic signed [CW-1:0] x0;
      logic signed [CW-1:0] y0;
      logic signed [CW-1:0] x1;
      logic signed [CW-1:0] y1;
   } box_type;

   // one entry of the front/back queue: a box plus group markers
   typedef struct packed {
      box_type box;
      logic    store;
      logic    last;
   } cmd_type;

   function automatic logic signed [CW-1:0] sat(input logic signed [WW-1:0] v);
      logic signed [WW-1:0] hi;
      logic signed [WW-1:0] lo;
      hi = WW'((64'sd1 <<< (CW-1)) - 1);
      lo = -hi - 1;
      if (v > hi) sat = hi[CW-1:0];
      else if (v < lo) sat = lo[CW-1:0];
      else sat = v[CW-1:0];
   endfunction
endpackage

FILE: rtl/gbl_ram.sv
module gbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/gbl_front.sv
module gbl_front import gbl_pkg::*; #(
   parameter int MAX_MEMBERS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  box_type        req_box,
   input  logic           req_last,
   output logic           q_valid,
   output cmd_type        q_data,
   input  logic           q_pop
);
   `include "group_box_layout_defines.svh"
   localparam int CNTW = $clog2(MAX_MEMBERS + 1);
   localparam int QD = 2;

   logic [CNTW-1:0] cnt_ff, cnt_in;
   cmd_type         q_ff [QD];
   logic [1:0]      qn_ff, qn_in;
   logic            acc;
   cmd_type         w;

   assign req_full = (qn_ff == 2'(QD));
   assign acc = req_push && !req_full;

   // classify: store while room, mark group end
   always_comb begin
      w.box = req_box;
      w.store = (cnt_ff < CNTW'(MAX_MEMBERS));
      w.last = req_last;
      cnt_in = cnt_ff;
      if (acc) begin
         if (req_last) cnt_in = '0;
         else if (w.store) cnt_in = cnt_ff + 1'b1;
      end
      qn_in = qn_ff + 2'(acc) - 2'(q_pop && q_valid);
   end

   assign q_valid = (qn_ff != 2'd0);
   assign q_data = q_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         qn_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         qn_ff <= qn_in;
      end
   end

   // two-entry shift queue; a full queue takes no new word, so a pop with
   // a push only happens with one word held
   always_ff @(posedge clock) begin
      if (q_pop && q_valid) begin
         if (acc && qn_ff == 2'd1) q_ff[0] <= w;
         else q_ff[0] <= q_ff[1];
      end else if (acc) begin
         q_ff[qn_ff[0]] <= w;
      end
   end

   `GBL_ASSERT(a_qbound, clock, reset, qn_ff <= 2'(QD), "queue overflow")
   `GBL_ASSERT(a_cnt, clock, reset, cnt_ff <= CNTW'(MAX_MEMBERS), "count overflow")
   `GBL_ASSERT(a_last, clock, reset, acc && req_last |=> cnt_ff == '0, "count not cleared")
endmodule

FILE: rtl/gbl_back.sv
module gbl_back import gbl_pkg::*; #(
   parameter int MAX_MEMBERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  cmd_type              q_data,
   output logic                 q_pop,
   input  logic                 mode,
   input  logic [CW-2:0]        margin,
   input  logic signed [CW-1:0] maxdif,
   input  logic signed [CW-1:0] orgx,
   input  logic signed [CW-1:0] orgy,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic signed [CW-1:0] rsp_offset_x,
   output logic signed [CW-1:0] rsp_offset_y,
   output logic                 rsp_last_offset
);
   `include "group_box_layout_defines.svh"
   localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
   localparam int CNTW = $clog2(MAX_MEMBERS + 1);

   localparam logic [3:0] S_LOAD = 4'd0;
   localparam logic [3:0] S_SUMR = 4'd1;
   localparam logic [3:0] S_SUMW = 4'd2;
   localparam logic [3:0] S_PRDA = 4'd3;
   localparam logic [3:0] S_PRDB = 4'd4;
   localparam logic [3:0] S_PCALC = 4'd5;
   localparam logic [3:0] S_PLACE = 4'd6;
   localparam logic [3:0] S_ORD = 4'd7;
   localparam logic [3:0] S_ORW = 4'd8;
   localparam logic [3:0] S_OUT = 4'd9;
   localparam logic [3:0] S_SHIFT = 4'd10;

   logic [3:0]           st_ff, st_in;
   logic [CNTW-1:0]      n_ff, n_in;
   logic [CNTW-1:0]      i_ff, i_in;
   logic signed [WW-1:0] acc_ff, acc_in;   // total / running x
   logic signed [WW-1:0] sb_y0_ff, sb_y1_ff, sb_y0_in, sb_y1_in;
   logic signed [WW-1:0] frh_ff, frh_in;
   logic signed [WW-1:0] shift_ff, shift_in;
   box_type              ba_ff, ba_in, bb_ff, bb_in;
   logic signed [WW-1:0] xc_ff, xc_in;
   logic [1:0]           ph_ff, ph_in;
   logic                 ov_ff, ov_in;
   logic signed [CW-1:0] ox_ff, oy_ff, ox_in, oy_in;
   logic                 ol_ff, ol_in;

   logic                 bw_en;
   logic [AW-1:0]        b_rd_addr, o_rd_addr, o_wr_addr;
   logic [4*CW-1:0]      b_rd;
   box_type              b_q;
   logic                 ow_en;
   logic [2*WW-1:0]      ow_data, o_rd;

   logic signed [WW-1:0] mg, xm, wa, wb, d, ad, oxa, oya, oxb, oyb, py;

   gbl_ram #(.WIDTH(4*CW), .DEPTH(MAX_MEMBERS)) u_box (
      .clock(clock), .wr_en(bw_en), .wr_addr(n_ff[AW-1:0]), .wr_data(q_data.box),
      .rd_addr(b_rd_addr), .rd_data(b_rd));
   gbl_ram #(.WIDTH(2*WW), .DEPTH(MAX_MEMBERS)) u_off (
      .clock(clock), .wr_en(ow_en), .wr_addr(o_wr_addr), .wr_data(ow_data),
      .rd_addr(o_rd_addr), .rd_data(o_rd));

   assign b_q = b_rd;
   assign mg = WW'($unsigned(margin));
   assign xm = mg >>> 1;
   assign wa = WW'(ba_ff.x1) - WW'(ba_ff.x0);
   assign wb = WW'(bb_ff.x1) - WW'(bb_ff.x0);
   assign d = wa - wb;
   assign ad = d[WW-1] ? -d : d;
   assign py = (i_ff == '0) ? '0 : sb_y1_ff + mg;
   assign oxa = xc_ff - xm - WW'(ba_ff.x1);
   assign oxb = xc_ff + xm - WW'(bb_ff.x0);
   assign oya = (i_ff == '0) ? -WW'(orgy) : py - WW'(ba_ff.y0);
   assign oyb = (i_ff == '0) ? -WW'(orgy) : py - WW'(bb_ff.y0);

   assign rsp_empty = !ov_ff;
   assign rsp_offset_x = ox_ff;
   assign rsp_offset_y = oy_ff;
   assign rsp_last_offset = ol_ff;

   // sequencer: load, then walk the store for sums/placement/output
   always_comb begin
      logic signed [WW-1:0] ya0, ya1, yb0, yb1, t0, t1;
      st_in = st_ff; n_in = n_ff; i_in = i_ff; acc_in = acc_ff;
      sb_y0_in = sb_y0_ff; sb_y1_in = sb_y1_ff; frh_in = frh_ff; shift_in = shift_ff;
      ba_in = ba_ff; bb_in = bb_ff; xc_in = xc_ff; ph_in = ph_ff;
      ov_in = ov_ff; ox_in = ox_ff; oy_in = oy_ff; ol_in = ol_ff;
      q_pop = 1'b0; bw_en = 1'b0; ow_en = 1'b0;
      b_rd_addr = i_ff[AW-1:0]; o_rd_addr = i_ff[AW-1:0]; o_wr_addr = i_ff[AW-1:0];
      ow_data = '0;
      ya0 = '0; ya1 = '0; yb0 = '0; yb1 = '0; t0 = '0; t1 = '0;
      if (ov_ff && rsp_pop) ov_in = 1'b0;
      case (st_ff)
         S_LOAD: begin
            if (q_valid) begin
               q_pop = 1'b1;
               bw_en = q_data.store;
               if (q_data.store) n_in = n_ff + 1'b1;
               if (q_data.last) begin
                  i_in = '0; ph_in = '0;
                  acc_in = '0; shift_in = '0;
                  if (!mode) begin
                     st_in = S_SUMR;
                  end else if ((q_data.store ? n_ff + 1'b1 : n_ff) == CNTW'(1)) begin
                     ow_en = 1'b1; o_wr_addr = '0;
                     ow_data = {-WW'(orgx), -WW'(orgy)};
                     st_in = S_OUT;
                  end else begin
                     st_in = S_PRDA;
                  end
               end
            end
         end
         S_SUMR: st_in = S_SUMW;   // read issued, data next cycle
         S_SUMW: begin
            // margin goes in after every member but the last
            if (i_ff + 1'b1 == n_ff) begin
               acc_in = -((acc_ff + WW'(b_q.x1) - WW'(b_q.x0)) >>> 1);
               i_in = '0; st_in = S_ORD;
            end else begin
               acc_in = acc_ff + WW'(b_q.x1) - WW'(b_q.x0) + mg;
               i_in = i_ff + 1'b1; st_in = S_SUMR;
            end
         end
         S_ORD: st_in = S_ORW;
         S_ORW: begin
            ow_en = 1'b1;
            ow_data = {acc_ff - WW'(b_q.x0), -WW'(orgy)};
            acc_in = acc_ff + WW'(b_q.x1) - WW'(b_q.x0) + mg;
            if (i_ff + 1'b1 == n_ff) begin
               i_in = '0; st_in = S_OUT;
            end else begin
               i_in = i_ff + 1'b1; st_in = S_ORD;
            end
         end
         S_PRDA: begin
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd1) ba_in = b_q;
            if (ph_ff == 2'd1) begin
               ph_in = '0;
               st_in = (i_ff + 1'b1 < n_ff) ? S_PRDB : S_PLACE;
            end
         end
         S_PRDB: begin
            b_rd_addr = AW'(i_ff + 1'b1);
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 2'd1) begin
               bb_in = b_q; ph_in = '0; st_in = S_PCALC;
            end
         end
         S_PCALC: begin
            xc_in = (maxdif[CW-1] || ad <= WW'(maxdif)) ? '0 : d;
            st_in = S_PLACE;
         end
         S_PLACE: begin
            // pair row or the unpaired tail box
            if (i_ff + 1'b1 < n_ff) begin
               ya0 = WW'(ba_ff.y0) + oya; ya1 = WW'(ba_ff.y1) + oya;
               yb0 = WW'(bb_ff.y0) + oyb; yb1 = WW'(bb_ff.y1) + oyb;
               t0 = (yb0 < ya0) ? yb0 : ya0;
               t1 = (yb1 > ya1) ? yb1 : ya1;
               if (ph_ff == 2'd0) begin
                  ow_en = 1'b1; ow_data = {oxa, oya}; ph_in = 2'd1;
               end else begin
                  ow_en = 1'b1; o_wr_addr = AW'(i_ff + 1'b1);
                  ow_data = {oxb, oyb}; ph_in = '0;
               end
            end else begin
               // tail box: x on the origin, top edge on the row line
               ya0 = WW'(ba_ff.y0) + oya;
               ya1 = WW'(ba_ff.y1) + oya;
               t0 = ya0; t1 = ya1;
               ow_en = 1'b1; ow_data = {-WW'(orgx), oya};
            end
            if (ow_en && (ph_ff != 2'd0 || !(i_ff + 1'b1 < n_ff))) begin
               if (i_ff == '0) begin
                  sb_y0_in = t0; sb_y1_in = t1; frh_in = t1 - t0;
               end else begin
                  sb_y0_in = (t0 < sb_y0_ff) ? t0 : sb_y0_ff;
                  sb_y1_in = (t1 > sb_y1_ff) ? t1 : sb_y1_ff;
               end
               if (i_ff + 2'd2 >= n_ff) begin
                  st_in = S_SHIFT; i_in = '0;
               end else begin
                  i_in = i_ff + 2'd2; st_in = S_PRDA;
               end
            end
         end
         S_SHIFT: begin
            shift_in = (frh_ff >>> 1) - ((sb_y1_ff - sb_y0_ff) >>> 1);
            st_in = S_OUT;
         end
         S_OUT: begin
            // read then present; ph 0 issue, ph 1 load output register
            if (ph_ff == 2'd0) begin
               ph_in = 2'd1;
            end else if (!ov_ff || rsp_pop) begin
               ov_in = 1'b1;
               ox_in = sat(o_rd[2*WW-1:WW]);
               oy_in = sat(o_rd[WW-1:0] + shift_ff);
               ol_in = (i_ff + 1'b1 == n_ff);
               ph_in = '0;
               if (i_ff + 1'b1 == n_ff) begin
                  st_in = S_LOAD; n_in = '0; i_in = '0;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD; n_ff <= '0; i_ff <= '0; ph_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; n_ff <= n_in; i_ff <= i_in; ph_ff <= ph_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; sb_y0_ff <= sb_y0_in; sb_y1_ff <= sb_y1_in;
      frh_ff <= frh_in; shift_ff <= shift_in; ba_ff <= ba_in; bb_ff <= bb_in;
      xc_ff <= xc_in; ox_ff <= ox_in; oy_ff <= oy_in; ol_ff <= ol_in;
   end

   `GBL_ASSERT(a_n, clock, reset, n_ff <= CNTW'(MAX_MEMBERS), "member count overflow")
   `GBL_ASSERT(a_pop, clock, reset, q_pop |-> st_ff == S_LOAD, "pop outside load")
   `GBL_ASSERT(a_hold, clock, reset, ov_ff && !rsp_pop |=> ov_ff, "result dropped")
endmodule

FILE: rtl/group_box_layout.sv
// Flow: a box word is registered in the input queue and, while the group has
// room, written to the box store when the sequencer takes it; the last word
// starts layout: row mode walks the store twice (sums, then offsets), pair
// mode reads and places each pair and an odd tail box, then each offset word
// is read out, held while pop stalls. One group is laid out at a time. Reset
// is synchronous, active high, clears control state and config to defaults.
module group_box_layout import gbl_pkg::*; #(
   parameter int MAX_MEMBERS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic signed [CW-1:0] req_box_min_x,
   input  logic signed [CW-1:0] req_box_min_y,
   input  logic signed [CW-1:0] req_box_max_x,
   input  logic signed [CW-1:0] req_box_max_y,
   input  logic                 req_last_box,
   output logic                 empty,
   input  logic                 pop,
   output logic signed [CW-1:0] rsp_offset_x,
   output logic signed [CW-1:0] rsp_offset_y,
   output logic                 rsp_last_offset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [CW-1:0]        csr_wdata
);
   logic                 mode_ff;
   logic [CW-2:0]        margin_ff;
   logic signed [CW-1:0] maxdif_ff, orgx_ff, orgy_ff;
   logic                 q_valid, q_pop;
   cmd_type              q_data;
   box_type              bx;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0; margin_ff <= '0; maxdif_ff <= '1;
         orgx_ff <= '0; orgy_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:   mode_ff <= csr_wdata[0];
            CSR_MARGIN: margin_ff <= csr_wdata[CW-2:0];
            CSR_MAXDIF: maxdif_ff <= csr_wdata;
            CSR_ORGX:   orgx_ff <= csr_wdata;
            CSR_ORGY:   orgy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign bx = '{x0: req_box_min_x, y0: req_box_min_y, x1: req_box_max_x, y1: req_box_max_y};

   gbl_front #(.MAX_MEMBERS(MAX_MEMBERS)) u_front (
      .clock(clock), .reset(reset), .req_push(push), .req_full(full),
      .req_box(bx), .req_last(req_last_box),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

   gbl_back #(.MAX_MEMBERS(MAX_MEMBERS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
      .mode(mode_ff), .margin(margin_ff), .maxdif(maxdif_ff),
      .orgx(orgx_ff), .orgy(orgy_ff),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_offset_x(rsp_offset_x),
      .rsp_offset_y(rsp_offset_y), .rsp_last_offset(rsp_last_offset));
endmodule

FILE: bench/group_box_layout_check.sv
// Watches the request, response and CSR ports, predicts the member offsets
// of each group and compares every popped word with the oldest prediction.
module group_box_layout_check import gbl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 full,
   input  logic signed [CW-1:0] req_box_min_x,
   input  logic signed [CW-1:0] req_box_min_y,
   input  logic signed [CW-1:0] req_box_max_x,
   input  logic signed [CW-1:0] req_box_max_y,
   input  logic                 req_last_box,
   input  logic                 empty,
   input  logic                 pop,
   input  logic signed [CW-1:0] rsp_offset_x,
   input  logic signed [CW-1:0] rsp_offset_y,
   input  logic                 rsp_last_offset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [CW-1:0]        csr_wdata,
   output int                   words_due,
   output int                   fail_count
);
   localparam int GROUP_MAX = 16;

   typedef struct {
      longint x0, y0, x1, y1;
   } rect_type;

   typedef struct {
      logic signed [CW-1:0] off_x;
      logic signed [CW-1:0] off_y;
      logic                 last;
   } offset_word_type;

   // layout settings as seen on the CSR port
   logic   pair_mode;
   longint margin;
   longint diff_limit;
   longint org_x;
   longint org_y;

   // group being loaded and its computed offsets
   rect_type members[GROUP_MAX];
   longint   off_x[GROUP_MAX];
   longint   off_y[GROUP_MAX];
   int       member_cnt;

   offset_word_type offsets_due[$];
   int              errors;

   assign fail_count = errors;

   function automatic longint halve(longint v);
      return v >>> 1;
   endfunction

   function automatic logic signed [CW-1:0] clamp(longint v);
      longint hi;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v[CW-1:0];
   endfunction

   function automatic longint width_of(int i);
      return members[i].x1 - members[i].x0;
   endfunction

   function automatic rect_type merge_rect(rect_type a, rect_type b);
      if (b.x0 < a.x0) a.x0 = b.x0;
      if (b.y0 < a.y0) a.y0 = b.y0;
      if (b.x1 > a.x1) a.x1 = b.x1;
      if (b.y1 > a.y1) a.y1 = b.y1;
      return a;
   endfunction

   // anchor member i at (x,y): side -1 aligns its max edge, +1 its min edge,
   // 0 the origin
   function automatic rect_type anchor(int i, longint x, longint y, int xs, int ys);
      rect_type b;
      longint   ox;
      longint   oy;
      b  = members[i];
      ox = x - (xs == 0 ? org_x : (xs < 0 ? b.x1 : b.x0));
      oy = y - (ys == 0 ? org_y : (ys < 0 ? b.y1 : b.y0));
      off_x[i] = ox;
      off_y[i] = oy;
      b.x0 += ox;
      b.x1 += ox;
      b.y0 += oy;
      b.y1 += oy;
      return b;
   endfunction

   function automatic rect_type place_pair(int i, int n, longint py, int ys, longint xm);
      longint   xc;
      longint   axc;
      rect_type lft;
      if (i + 1 < n) begin
         xc  = width_of(i) - width_of(i + 1);
         axc = xc < 0 ? -xc : xc;
         if (diff_limit < 0 || axc <= diff_limit) xc = 0;
         lft = anchor(i, xc - xm, py, -1, ys);
         return merge_rect(lft, anchor(i + 1, xc + xm, py, 1, ys));
      end
      return anchor(i, 0, py, 0, ys);
   endfunction

   // compute offsets for the loaded group and queue the expected words
   function automatic void lay_out_group(int n);
      longint          total;
      longint          cur_x;
      longint          xm;
      longint          row0_h;
      longint          shift;
      rect_type        stack;
      offset_word_type w;
      if (!pair_mode) begin
         total = longint'(n - 1) * margin;
         for (int i = 0; i < n; i++) total += width_of(i);
         cur_x = -halve(total);
         for (int i = 0; i < n; i++) begin
            off_x[i] = cur_x - members[i].x0;
            off_y[i] = -org_y;
            cur_x += width_of(i) + margin;
         end
      end else if (n == 1) begin
         off_x[0] = -org_x;
         off_y[0] = -org_y;
      end else begin
         xm     = halve(margin);
         stack  = place_pair(0, n, 0, 0, xm);
         row0_h = stack.y1 - stack.y0;
         for (int i = 2; i < n; i += 2)
            stack = merge_rect(stack, place_pair(i, n, stack.y1 + margin, 1, xm));
         shift = halve(row0_h) - halve(stack.y1 - stack.y0);
         for (int i = 0; i < n; i++) off_y[i] += shift;
      end
      for (int i = 0; i < n; i++) begin
         w.off_x = clamp(off_x[i]);
         w.off_y = clamp(off_y[i]);
         w.last  = (i + 1 == n);
         offsets_due.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      offset_word_type w;
      if (reset) begin
         pair_mode  = 1'b0;
         margin     = 0;
         diff_limit = -1;
         org_x      = 0;
         org_y      = 0;
         member_cnt = 0;
         errors     = 0;
         offsets_due.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_MODE:   pair_mode  = csr_wdata[0];
               CSR_MARGIN: margin     = longint'(csr_wdata[CW-2:0]);
               CSR_MAXDIF: diff_limit = longint'($signed(csr_wdata));
               CSR_ORGX:   org_x      = longint'($signed(csr_wdata));
               CSR_ORGY:   org_y      = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         // response side
         if (pop && !empty) begin
            if (offsets_due.size() == 0) begin
               $error("unexpected offset word x=%0d y=%0d", rsp_offset_x, rsp_offset_y);
               errors++;
            end else begin
               w = offsets_due.pop_front();
               if (rsp_offset_x !== w.off_x) begin
                  $error("offset_x expected %0d got %0d", w.off_x, rsp_offset_x);
                  errors++;
               end
               if (rsp_offset_y !== w.off_y) begin
                  $error("offset_y expected %0d got %0d", w.off_y, rsp_offset_y);
                  errors++;
               end
               if (rsp_last_offset !== w.last) begin
                  $error("last_offset expected %0d got %0d", w.last, rsp_last_offset);
                  errors++;
               end
            end
         end
         // request side; boxes beyond the group limit are dropped
         if (push && !full) begin
            if (member_cnt < GROUP_MAX) begin
               members[member_cnt].x0 = longint'(req_box_min_x);
               members[member_cnt].y0 = longint'(req_box_min_y);
               members[member_cnt].x1 = longint'(req_box_max_x);
               members[member_cnt].y1 = longint'(req_box_max_y);
               member_cnt++;
            end
            if (req_last_box) begin
               lay_out_group(member_cnt);
               member_cnt = 0;
            end
         end
      end
      words_due <= offsets_due.size();
   end

   final begin
      if (offsets_due.size() != 0)
         $error("%0d offset words never arrived", offsets_due.size());
   end
endmodule

FILE: bench/tb_top.sv
// Drives box groups and layout settings into group_box_layout; the checker
// predicts and compares the offset words.
module tb_top;
   import gbl_pkg::*;

   localparam int  RANDOM_BOXES = 450;
   localparam int  CYCLE_LIMIT  = 2000000;
   localparam int  SETTLE       = 200;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic signed [CW-1:0] req_box_min_x = '0;
   logic signed [CW-1:0] req_box_min_y = '0;
   logic signed [CW-1:0] req_box_max_x = '0;
   logic signed [CW-1:0] req_box_max_y = '0;
   logic                 req_last_box = 1'b0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic signed [CW-1:0] rsp_offset_x;
   logic signed [CW-1:0] rsp_offset_y;
   logic                 rsp_last_offset;
   logic                 csr_we = 1'b0;
   logic [2:0]           csr_index = CSR_MODE;
   logic [CW-1:0]        csr_wdata = '0;

   int words_due;
   int fail_count;
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int hold_requests = 0;
   int boxes_sent = 0;
   int cycles = 0;

   always #6 clock = ~clock;

   group_box_layout DUT (.*);

   group_box_layout_check checker_i (.*);

   // receiver: random stalls plus long hold-offs on request
   always @(posedge clock) begin
      int hold_left;
      int holds_done;
      if (reset) begin
         pop        <= 1'b0;
         hold_left  = 0;
         holds_done = 0;
      end else if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left--;
      end else if (holds_done < hold_requests) begin
         pop <= 1'b0;
         holds_done++;
         hold_left = 400;
      end else begin
         pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_box(logic signed [CW-1:0] x0, logic signed [CW-1:0] y0,
                           logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
                           logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push          <= 1'b1;
      req_box_min_x <= x0;
      req_box_min_y <= y0;
      req_box_max_x <= x1;
      req_box_max_y <= y1;
      req_last_box  <= last;
      @(posedge clock);
      while (full) @(posedge clock);
      boxes_sent++;
   endtask

   task automatic drain;
      push <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // all five registers, written back to back while the block is idle
   task automatic write_regs(logic pm, logic [CW-1:0] mg, logic [CW-1:0] md,
                             logic [CW-1:0] ox, logic [CW-1:0] oy);
      logic [2:0]    idx[5];
      logic [CW-1:0] val[5];
      idx = '{CSR_MODE, CSR_MARGIN, CSR_MAXDIF, CSR_ORGX, CSR_ORGY};
      val = '{{23'd0, pm}, mg, md, ox, oy};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] pick_coord();
      case ($urandom_range(9))
         0:       return CW'($urandom);
         1:       return {1'b0, {(CW-1){1'b1}}};
         2:       return {1'b1, {(CW-1){1'b0}}};
         default: return $signed(CW'($urandom_range(8191)) - CW'(4096));
      endcase
   endfunction

   function automatic logic [CW-1:0] pick_margin();
      case ($urandom_range(5))
         0:       return '0;
         1:       return {1'b0, {(CW-1){1'b1}}};
         2:       return CW'($urandom) & {1'b0, {(CW-1){1'b1}}};
         default: return CW'($urandom_range(1024));
      endcase
   endfunction

   function automatic logic [CW-1:0] pick_maxdiff();
      case ($urandom_range(5))
         0:       return '1;
         1:       return {1'b0, {(CW-1){1'b1}}};
         2:       return '0;
         3:       return CW'($urandom) | {1'b1, {(CW-1){1'b0}}};
         default: return CW'($urandom_range(2048));
      endcase
   endfunction

   task automatic send_group(int n);
      logic signed [CW-1:0] a;
      logic signed [CW-1:0] b;
      logic signed [CW-1:0] c;
      logic signed [CW-1:0] d;
      for (int i = 0; i < n; i++) begin
         a = pick_coord();
         b = pick_coord();
         c = pick_coord();
         d = pick_coord();
         // mostly well-formed boxes, now and then inverted
         if ($urandom_range(7) != 0) begin
            if (c < a) {a, c} = {c, a};
            if (d < b) {b, d} = {d, b};
         end
         send_box(a, b, c, d, i == n - 1);
      end
   endtask

   initial begin
      int phase;
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: row mode at reset settings
      send_box(-24'sd100, -24'sd50, 24'sd100, 24'sd50, 1'b1);
      send_box(24'sd10, 24'sd0, 24'sd30, 24'sd20, 1'b0);
      send_box(24'sd40, -24'sd10, 24'sd0, 24'sd5, 1'b1);   // inverted box
      drain();
      write_regs(1'b0, {1'b0, {(CW-1){1'b1}}}, '1,
                 {1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}});
      send_box({1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}},
               {1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}}, 1'b0);
      send_box({1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}},
               {1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}}, 1'b1);
      drain();
      // pair mode: single box, even pair with shift, odd count
      write_regs(1'b1, 24'd64, 24'd0, 24'sd300, -24'sd200);
      send_box(24'sd5, 24'sd5, 24'sd25, 24'sd25, 1'b1);
      send_box(24'sd0, 24'sd0, 24'sd100, 24'sd40, 1'b0);
      send_box(24'sd0, 24'sd0, 24'sd20, 24'sd60, 1'b1);
      send_group(3);
      drain();
      // oversized group: boxes past the limit are dropped
      write_regs(1'b1, 24'd16, {1'b0, {(CW-1){1'b1}}}, '0, '0);
      send_group(19);
      drain();

      // random phases with changing settings and idling patterns
      phase = 0;
      while (boxes_sent < RANDOM_BOXES - 20) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 51; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 51; end
            default: begin send_idle_pct = 32; pop_stall_pct = 32; end
         endcase
         write_regs(1'($urandom_range(1)), pick_margin(), pick_maxdiff(),
                    pick_coord(), pick_coord());
         if (phase == 2) hold_requests++;
         for (int g = 0; g < 8; g++) begin
            case ($urandom_range(19))
               0:       n = 16 + $urandom_range(3);
               1, 2:    n = $urandom_range(7, 15);
               default: n = $urandom_range(1, 6);
            endcase
            send_group(n);
         end
         drain();
         phase++;
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl
rtl/gbl_pkg.sv
rtl/gbl_ram.sv
rtl/gbl_front.sv
rtl/gbl_back.sv
rtl/group_box_layout.sv
bench/group_box_layout_check.sv
bench/tb_top.sv
